// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared constants, register indexes and arithmetic helpers for the
// pressure / temperature compensation core
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int DIV_STAGES = 32;
  localparam int SIDE_W     = 53;

  typedef enum logic [2:0] {
    CFG_COEF_A = 3'd0,
    CFG_COEF_B = 3'd1,
    CFG_COEF_C = 3'd2,
    CFG_COEF_D = 3'd3,
    CFG_OSS    = 3'd4
  } cfg_idx_t;

  // sign-extend a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // arithmetic shift right of a 32-bit two's complement word
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

// ===== design/bpc_udiv.sv =====
// ----------------------------------------------------------------------------
// bpc_udiv
// unsigned 32/32 restoring divider, one quotient bit per pipeline stage,
// with a side bus that travels alongside each division
// ----------------------------------------------------------------------------
module bpc_udiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [31:0]                num,
  input  logic [31:0]                den,
  input  logic [bpc_pkg::SIDE_W-1:0] side,
  output logic                       out_valid,
  output logic [31:0]                quo,
  output logic [bpc_pkg::SIDE_W-1:0] side_out
);

  localparam int N = bpc_pkg::DIV_STAGES;

  logic [N-1:0]                vld;
  logic [31:0]                 rem   [N];
  logic [31:0]                 nsh   [N];
  logic [31:0]                 dvs   [N];
  logic [31:0]                 qacc  [N];
  logic [bpc_pkg::SIDE_W-1:0]  sd    [N];

  logic [31:0]                 rp    [N];
  logic [31:0]                 np    [N];
  logic [31:0]                 dp    [N];
  logic [31:0]                 qp    [N];
  logic [bpc_pkg::SIDE_W-1:0]  sp    [N];
  logic [N-1:0]                vp;
  logic [32:0]                 trial [N];
  logic [N-1:0]                ge;

  always_comb begin
    rp[0] = '0;
    np[0] = num;
    dp[0] = den;
    qp[0] = '0;
    sp[0] = side;
    vp[0] = in_valid;
    for (int k = 1; k < N; k++) begin
      rp[k] = rem[k-1];
      np[k] = nsh[k-1];
      dp[k] = dvs[k-1];
      qp[k] = qacc[k-1];
      sp[k] = sd[k-1];
      vp[k] = vld[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = {rp[k], np[k][31]};
      ge[k]    = trial[k] >= {1'b0, dp[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem[k]  <= ge[k] ? 32'(trial[k] - {1'b0, dp[k]}) : trial[k][31:0];
        nsh[k]  <= {np[k][30:0], 1'b0};
        dvs[k]  <= dp[k];
        qacc[k] <= {qp[k][30:0], ge[k]};
        sd[k]   <= sp[k];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = qacc[N-1];
  assign side_out  = sd[N-1];

endmodule

// ===== design/baro_pressure_temp_compensation_core.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core
// datasheet 32-bit integer compensation of raw temperature and pressure
// ----------------------------------------------------------------------------
// throughput: one beat per cycle; 32-stage dividers for x2 and the pressure
//   quotient set the depth, and no stage chains one multiply into another
// the whole pipeline holds while the output beat waits for m_tready
// reset (rst, synchronous): valids clear, coefficients 0, oversampling 3
module baro_pressure_temp_compensation_core (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature [15:0], raw_pressure [34:16]
  // output beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // temperature_tenths [15:0], pressure_pa [47:16]
  output logic        m_tuser    // divide_error
);

  // configuration registers
  logic [47:0] coef_a, coef_b;
  logic [31:0] coef_c, coef_d;
  logic [1:0]  oss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      coef_d <= '0;
      oss    <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::CFG_COEF_A: coef_a <= cfg_data;
        bpc_pkg::CFG_COEF_B: coef_b <= cfg_data;
        bpc_pkg::CFG_COEF_C: coef_c <= cfg_data[31:0];
        bpc_pkg::CFG_COEF_D: coef_d <= cfg_data[31:0];
        bpc_pkg::CFG_OSS:    oss    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(coef_a[47:32]);
  assign ac2 = bpc_pkg::sx16(coef_a[31:16]);
  assign ac3 = bpc_pkg::sx16(coef_a[15:0]);
  assign ac4 = {16'd0, coef_b[47:32]};
  assign ac5 = {16'd0, coef_b[31:16]};
  assign ac6 = {16'd0, coef_b[15:0]};
  assign b1  = bpc_pkg::sx16(coef_c[31:16]);
  assign b2  = bpc_pkg::sx16(coef_c[15:0]);
  assign mc  = bpc_pkg::sx16(coef_d[31:16]);
  assign md  = bpc_pkg::sx16(coef_d[15:0]);

  // global advance: everything moves unless the output beat is stuck
  logic ov, adv;
  assign adv      = !ov || m_tready;
  assign s_tready = adv;

  logic [15:0] ut_in;
  logic [18:0] up_in;
  assign ut_in = s_tdata[15:0];
  assign up_in = s_tdata[34:16];

  // stage valids
  logic va, vb, vc, vd, ve, vf, vg, vh, vi, vj, vk, vl, vm, vn, vo;
  logic d1_v, d2_v;

  // stage a: (ut - ac6) * ac5
  logic [31:0] prod_a;
  logic [18:0] up_a;
  // stage b: x1 and the temperature divisor
  logic [31:0] x1_b, den_b;
  logic [18:0] up_b;
  // stage c: magnitudes and sign for the divider
  logic [31:0] x1_c, num_mag_c, den_mag_c;
  logic [18:0] up_c;
  logic        neg_c, err_c;
  // divider 1 output
  logic [31:0]                 d1_q;
  logic [bpc_pkg::SIDE_W-1:0]  d1_side;
  // stage d: b5
  logic [31:0] b5_d;
  logic [18:0] up_d;
  logic        err_d;
  // stage e: temperature and b6
  logic [15:0] t_e;
  logic [31:0] b6_e;
  logic [18:0] up_e;
  logic        err_e;
  // stage f: first products
  logic [31:0] b6sq_f, ac2b6_f, ac3b6_f;
  logic [15:0] t_f;
  logic [18:0] up_f;
  logic        err_f;
  // stage g
  logic [31:0] sq_g, x2a_g, x1b_g;
  logic [15:0] t_g;
  logic [18:0] up_g;
  logic        err_g;
  // stage h
  logic [31:0] b2sq_h, b1sq_h, x2a_h, x1b_h;
  logic [15:0] t_h;
  logic [18:0] up_h;
  logic        err_h;
  // stage i: b3 and x3
  logic [31:0] b3_i, x3_i;
  logic [15:0] t_i;
  logic [18:0] up_i;
  logic        err_i;
  // stage j
  logic [31:0] b4p_j, dif_j;
  logic [15:0] t_j;
  logic        err_j;
  // stage k: b4 and b7
  logic [31:0] b4_k, b7_k;
  logic [15:0] t_k;
  logic        err_k;
  // stage l: pressure divider operands
  logic [31:0] num_l, den_l;
  logic [15:0] t_l;
  logic        big_l, err_l;
  // divider 2 output
  logic [31:0]                 d2_q;
  logic [bpc_pkg::SIDE_W-1:0]  d2_side;
  // stage m: p
  logic [31:0] p_m;
  logic [15:0] t_m;
  logic        err_m;
  // stage n
  logic [31:0] p_n, pp_n, m7_n;
  logic [15:0] t_n;
  logic        err_n;
  // stage o
  logic [31:0] p_o, pm_o, x2_o;
  logic [15:0] t_o;
  logic        err_o;
  // output register
  logic [31:0] pr_out;
  logic [15:0] t_out;
  logic        err_out;

  // combinational helpers
  logic [31:0] x1_a_next, den_next, mc_num, num_abs, den_abs;
  logic [31:0] b5_next, tt, x3_next, b3_next, x3b_next, pr_next, p_next;
  logic [31:0] b7_scale;
  logic [15:0] t_next;
  logic        d1_err, d1_neg, d2_err, d2_big;
  logic [18:0] d1_up;
  logic [31:0] d1_x1;
  logic [15:0] d2_t;

  assign x1_a_next = bpc_pkg::asr(prod_a, 5'd15);
  assign den_next  = x1_a_next + md;
  assign mc_num    = mc << 11;
  assign num_abs   = mc_num[31] ? 32'(-mc_num) : mc_num;
  assign den_abs   = den_b[31] ? 32'(-den_b) : den_b;

  assign {d1_err, d1_neg, d1_up, d1_x1} = d1_side;
  assign b5_next = d1_x1 + (d1_neg ? 32'(-d1_q) : d1_q);

  // temperature: (b5 + 8) >> 4, saturated to 16 bits
  assign tt = bpc_pkg::asr(b5_d + 32'd8, 5'd4);
  always_comb begin
    if ($signed(tt) > 32'sd32767) begin
      t_next = 16'h7fff;
    end else if ($signed(tt) < -32'sd32768) begin
      t_next = 16'h8000;
    end else begin
      t_next = tt[15:0];
    end
  end

  assign x3_next  = bpc_pkg::asr(b2sq_h, 5'd11) + x2a_h;
  assign b3_next  = bpc_pkg::asr((((ac1 << 2) + x3_next) << oss) + 32'd2, 5'd2);
  assign x3b_next = bpc_pkg::asr(bpc_pkg::asr(b1sq_h, 5'd16) + x1b_h + 32'd2, 5'd2);
  assign b7_scale = 32'd50000 >> oss;

  assign d2_err = d2_side[17];
  assign d2_big = d2_side[16];
  assign d2_t   = d2_side[15:0];
  assign p_next = d2_big ? {d2_q[30:0], 1'b0} : d2_q;

  assign pr_next = p_o + bpc_pkg::asr(bpc_pkg::asr(pm_o, 5'd16) + x2_o + 32'd3791, 5'd4);

  // valid chain outside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh, vi, vj, vk, vl, vm, vn, vo, ov} <= '0;
    end else if (adv) begin
      va <= s_tvalid;
      vb <= va;
      vc <= vb;
      vd <= d1_v;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= vi;
      vk <= vj;
      vl <= vk;
      vm <= d2_v;
      vn <= vm;
      vo <= vn;
      ov <= vo;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a    <= ({16'd0, ut_in} - ac6) * ac5;
      up_a      <= up_in;

      x1_b      <= x1_a_next;
      den_b     <= den_next;
      up_b      <= up_a;

      x1_c      <= x1_b;
      num_mag_c <= num_abs;
      den_mag_c <= den_abs;
      neg_c     <= mc_num[31] ^ den_b[31];
      err_c     <= den_b == 32'd0;
      up_c      <= up_b;

      b5_d      <= b5_next;
      up_d      <= d1_up;
      err_d     <= d1_err;

      t_e       <= t_next;
      b6_e      <= b5_d - 32'd4000;
      up_e      <= up_d;
      err_e     <= err_d;

      b6sq_f    <= b6_e * b6_e;
      ac2b6_f   <= ac2 * b6_e;
      ac3b6_f   <= ac3 * b6_e;
      t_f       <= t_e;
      up_f      <= up_e;
      err_f     <= err_e;

      sq_g      <= bpc_pkg::asr(b6sq_f, 5'd12);
      x2a_g     <= bpc_pkg::asr(ac2b6_f, 5'd11);
      x1b_g     <= bpc_pkg::asr(ac3b6_f, 5'd13);
      t_g       <= t_f;
      up_g      <= up_f;
      err_g     <= err_f;

      b2sq_h    <= b2 * sq_g;
      b1sq_h    <= b1 * sq_g;
      x2a_h     <= x2a_g;
      x1b_h     <= x1b_g;
      t_h       <= t_g;
      up_h      <= up_g;
      err_h     <= err_g;

      b3_i      <= b3_next;
      x3_i      <= x3b_next;
      t_i       <= t_h;
      up_i      <= up_h;
      err_i     <= err_h;

      b4p_j     <= ac4 * (x3_i + 32'd32768);
      dif_j     <= {13'd0, up_i} - b3_i;
      t_j       <= t_i;
      err_j     <= err_i;

      b4_k      <= b4p_j >> 15;
      b7_k      <= dif_j * b7_scale;
      t_k       <= t_j;
      err_k     <= err_j;

      // b7 below 2^31 divides b7*2, otherwise b7 and doubles the quotient
      num_l     <= b7_k[31] ? b7_k : {b7_k[30:0], 1'b0};
      den_l     <= b4_k;
      big_l     <= b7_k[31];
      err_l     <= err_k || (b4_k == 32'd0);
      t_l       <= t_k;

      p_m       <= p_next;
      t_m       <= d2_t;
      err_m     <= d2_err;

      p_n       <= p_m;
      pp_n      <= bpc_pkg::asr(p_m, 5'd8) * bpc_pkg::asr(p_m, 5'd8);
      m7_n      <= 32'd7357 * p_m;
      t_n       <= t_m;
      err_n     <= err_m;

      p_o       <= p_n;
      pm_o      <= pp_n * 32'd3038;
      x2_o      <= bpc_pkg::asr(32'(-m7_n), 5'd16);
      t_o       <= t_n;
      err_o     <= err_n;

      // zero both results on a divide error
      pr_out    <= err_o ? 32'd0 : pr_next;
      t_out     <= err_o ? 16'd0 : t_o;
      err_out   <= err_o;
    end
  end

  // x2 = (mc << 11) / (x1 + md), on magnitudes
  bpc_udiv u_div_temp (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vc),
    .num       (num_mag_c),
    .den       (den_mag_c),
    .side      ({err_c, neg_c, up_c, x1_c}),
    .out_valid (d1_v),
    .quo       (d1_q),
    .side_out  (d1_side)
  );

  // pressure quotient against b4
  bpc_udiv u_div_press (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vl),
    .num       (num_l),
    .den       (den_l),
    .side      ({35'd0, err_l, big_l, t_l}),
    .out_valid (d2_v),
    .quo       (d2_q),
    .side_out  (d2_side)
  );

  assign m_tvalid = ov;
  assign m_tdata  = {pr_out, t_out};
  assign m_tuser  = err_out;

endmodule

// ===== bench/baro_pressure_temp_compensation_core_test.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core_test
// self-checking bench: a directed table with typed divide-error rows, then random calibration phases;
// all other output beats are compared against an in-bench compensation predictor
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 100;   // idle wait after the last expected beat
  localparam int          HOLD_CYCLES  = 400;   // long receiver stall, deeper than the pipe
  localparam logic [2:0]  CFG_IDX_SPARE = 3'd5; // indexes past the register list
  localparam logic [2:0]  CFG_IDX_TOP   = 3'd7;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic [31:0]        press_pa;
    logic               div_err;
  } comp_result_t;

  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   idx;
    logic [47:0]  value;
    logic [15:0]  ut;
    logic [18:0]  up;
    bit           typed;
    comp_result_t result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // raw_temperature [15:0], raw_pressure [34:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // temperature_tenths [15:0], pressure_pa [47:16]
  logic        m_tuser;        // divide_error

  // calibration as the bench believes the block holds it
  logic [47:0] cal_a = '0, cal_b = '0;
  logic [31:0] cal_c = '0, cal_d = '0;
  logic [1:0]  cal_oss = 2'd3;

  comp_result_t pending_results[$];
  stim_row_t    dir_rows[$];
  int           err_count = 0;
  int           cycle_count = 0;

  // typed expectation riding along with the beat currently offered
  bit           beat_typed = 1'b0;
  comp_result_t beat_result = '0;

  // sender burst shaping
  int burst_left = 0;

  // receiver stall control
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  baro_pressure_temp_compensation_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] sar32(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] widen_s16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // datasheet integer compensation, every intermediate wraps at 32 bits
  function automatic comp_result_t compensate(input logic [15:0] ut_in,
                                              input logic [18:0] up_in);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, den, sq, tmp;
    logic signed [31:0] t32;
    comp_result_t r;
    ac1 = widen_s16(cal_a[47:32]);
    ac2 = widen_s16(cal_a[31:16]);
    ac3 = widen_s16(cal_a[15:0]);
    ac4 = {16'd0, cal_b[47:32]};
    ac5 = {16'd0, cal_b[31:16]};
    ac6 = {16'd0, cal_b[15:0]};
    b1  = widen_s16(cal_c[31:16]);
    b2  = widen_s16(cal_c[15:0]);
    mc  = widen_s16(cal_d[31:16]);
    md  = widen_s16(cal_d[15:0]);
    ut  = {16'd0, ut_in};
    up  = {13'd0, up_in};
    r   = '{temp_tenths: '0, press_pa: '0, div_err: 1'b1};

    tmp = ut - ac6;
    tmp = tmp * ac5;
    x1  = sar32(tmp, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    tmp = mc << 11;
    x2  = $unsigned($signed(tmp) / $signed(den));
    b5  = x1 + x2;
    t32 = $signed(sar32(b5 + 32'd8, 4));
    if (t32 > 32767) t32 = 32767;
    if (t32 < -32768) t32 = -32768;

    b6  = b5 - 32'd4000;
    tmp = b6 * b6;
    sq  = sar32(tmp, 12);
    tmp = b2 * sq;
    x1  = sar32(tmp, 11);
    tmp = ac2 * b6;
    x2  = sar32(tmp, 11);
    x3  = x1 + x2;
    tmp = ac1 * 32'd4 + x3;
    tmp = tmp << cal_oss;
    b3  = sar32(tmp + 32'd2, 2);
    tmp = ac3 * b6;
    x1  = sar32(tmp, 13);
    tmp = b1 * sq;
    x2  = sar32(tmp, 16);
    x3  = sar32(x1 + x2 + 32'd2, 2);
    tmp = ac4 * (x3 + 32'd32768);
    b4  = tmp >> 15;
    if (b4 == 32'd0) return r;
    tmp = up - b3;
    b7  = tmp * (32'd50000 >> cal_oss);
    // unsigned quotient; when b7 would overflow on doubling, b7 is divided first and the quotient doubled
    if (b7 < 32'h8000_0000) begin
      tmp = b7 * 32'd2;
      p   = tmp / b4;
    end else begin
      tmp = b7 / b4;
      p   = tmp * 32'd2;
    end

    x1  = sar32(p, 8) * sar32(p, 8);
    tmp = x1 * 32'd3038;
    x1  = sar32(tmp, 16);
    tmp = 32'd0 - 32'd7357 * p;
    x2  = sar32(tmp, 16);
    r.press_pa    = p + sar32(x1 + x2 + 32'd3791, 4);
    r.temp_tenths = t32[15:0];
    r.div_err     = 1'b0;
    return r;
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // accepted beats on every side, sampled at the edge with pre-edge values
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpc_pkg::CFG_COEF_A: cal_a   <= cfg_data;
          bpc_pkg::CFG_COEF_B: cal_b   <= cfg_data;
          bpc_pkg::CFG_COEF_C: cal_c   <= cfg_data[31:0];
          bpc_pkg::CFG_COEF_D: cal_d   <= cfg_data[31:0];
          bpc_pkg::CFG_OSS:    cal_oss <= cfg_data[1:0];
          default: ;  // spare index, write dropped
        endcase
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(beat_typed ? beat_result
                                             : compensate(s_tdata[15:0], s_tdata[34:16]));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[15:0] !== want.temp_tenths)
            report_mismatch("temperature_tenths", {16'd0, m_tdata[15:0]},
                            {16'd0, want.temp_tenths});
          if (m_tdata[47:16] !== want.press_pa)
            report_mismatch("pressure_pa", m_tdata[47:16], want.press_pa);
          if (m_tuser !== want.div_err)
            report_mismatch("divide_error", {31'd0, m_tuser}, {31'd0, want.div_err});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------ receiver

  // long hold-off, counted on its own once the stimulus asks for it
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // stall pattern: switches between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(16, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (hold_left != 0)   m_tready <= 1'b0;
      else if (rx_mode == 0) m_tready <= 1'b1;
      else if (rx_mode == 1) m_tready <= 1'($urandom_range(0, 1));
      else                   m_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // ------------------------------------------------------------------ stimulus

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // offers one beat, keeping valid high across back-to-back beats of a burst
  task automatic send_sample(input logic [15:0] ut, input logic [18:0] up,
                             input bit typed, input comp_result_t result,
                             input bit gaps);
    int gap;
    if (gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    s_tvalid    <= 1'b1;
    s_tdata     <= {5'd0, up, ut};
    beat_typed  <= typed;
    beat_result <= result;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic void add_cfg(input logic [2:0] idx, input logic [47:0] value);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.value = value;
    row.typed = 1'b0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [15:0] ut, input logic [18:0] up,
                                     input bit div_err_typed);
    stim_row_t row;
    row.kind   = ROW_SAMPLE;
    row.ut     = ut;
    row.up     = up;
    row.typed  = div_err_typed;
    row.result = '{temp_tenths: '0, press_pa: '0, div_err: 1'b1};
    dir_rows.push_back(row);
  endfunction

  initial begin
    logic [15:0] ac6_now;
    logic [15:0] ut;
    logic [18:0] up;
    int          kind;
    comp_result_t none;
    none = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset every coefficient is zero, so the temperature divisor is zero
    add_sample(16'h0000, 19'h00000, 1'b1);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    add_sample(16'h8000, 19'h40000, 1'b1);
    // typical calibration, oversampling 0
    add_cfg(bpc_pkg::CFG_COEF_A, {16'd408, 16'hFFB8, 16'hC7D1});
    add_cfg(bpc_pkg::CFG_COEF_B, {16'd32741, 16'd32757, 16'd23153});
    add_cfg(bpc_pkg::CFG_COEF_C, {16'hFFFF, 16'd6190, 16'd4});       // upper bits dropped
    add_cfg(bpc_pkg::CFG_COEF_D, {16'h0000, 16'hDDF9, 16'd2868});
    add_cfg(bpc_pkg::CFG_OSS, 48'd0);
    add_sample(16'd27898, 19'd23843, 1'b0);
    add_sample(16'h0000, 19'h00000, 1'b0);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b0);
    add_sample(16'hFFFF, 19'h00000, 1'b0);
    add_sample(16'h0000, 19'h7FFFF, 1'b0);
    // spare indexes must leave the calibration alone
    add_cfg(CFG_IDX_SPARE, 48'hFFFF_FFFF_FFFF);
    add_cfg(CFG_IDX_TOP, 48'h0);
    add_sample(16'd27898, 19'd23843, 1'b0);
    add_cfg(bpc_pkg::CFG_OSS, 48'hFFFF_FFFF_FFFF);                  // oversampling 3
    add_sample(16'd27898, 19'd190744, 1'b0);
    add_sample(16'h7FFF, 19'h3FFFF, 1'b0);
    // md = 0 and raw temperature equal to ac6: temperature divisor zero
    add_cfg(bpc_pkg::CFG_COEF_D, {16'h0000, 16'hDDF9, 16'h0000});
    add_sample(16'd23153, 19'd23843, 1'b1);
    add_sample(16'd23154, 19'd23843, 1'b0);
    // ac4 = 0: pressure divisor zero
    add_cfg(bpc_pkg::CFG_COEF_D, {16'h0000, 16'hDDF9, 16'd2868});
    add_cfg(bpc_pkg::CFG_COEF_B, {16'd0, 16'd32757, 16'd23153});
    add_sample(16'd27898, 19'd23843, 1'b1);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    // extreme coefficients
    add_cfg(bpc_pkg::CFG_COEF_A, 48'hFFFF_FFFF_FFFF);
    add_cfg(bpc_pkg::CFG_COEF_B, 48'hFFFF_FFFF_FFFF);
    add_cfg(bpc_pkg::CFG_COEF_C, 48'h0000_7FFF_8000);
    add_cfg(bpc_pkg::CFG_COEF_D, 48'h0000_8000_7FFF);
    add_sample(16'h0000, 19'h00000, 1'b0);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b0);
    add_sample(16'h5555, 19'h2AAAA, 1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        s_tvalid <= 1'b0;
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].typed,
                    dir_rows[i].result, 1'b0);
      end
    end

    // random phases, each with its own calibration
    for (int ph = 0; ph < 10; ph++) begin
      s_tvalid <= 1'b0;
      wait_idle();
      kind = (ph == 3) ? 2 : (ph == 6) ? 3 : $urandom_range(0, 1);
      if (kind == 0) begin
        // near the typical part, low bits scrambled
        write_reg(bpc_pkg::CFG_COEF_A, {16'd408 ^ 16'($urandom_range(0, 255)),
                                        16'hFFB8 ^ 16'($urandom_range(0, 63)),
                                        16'hC7D1 ^ 16'($urandom_range(0, 1023))});
        write_reg(bpc_pkg::CFG_COEF_B, {16'd32741 ^ 16'($urandom_range(0, 1023)),
                                        16'd32757 ^ 16'($urandom_range(0, 1023)),
                                        16'd23153 ^ 16'($urandom_range(0, 4095))});
        write_reg(bpc_pkg::CFG_COEF_C, {16'($urandom),
                                        16'd6190 ^ 16'($urandom_range(0, 511)),
                                        16'($urandom_range(0, 15))});
        write_reg(bpc_pkg::CFG_COEF_D, {16'($urandom),
                                        16'hDDF9 ^ 16'($urandom_range(0, 1023)),
                                        (ph == 5) ? 16'h0000
                                                  : 16'd2868 ^ 16'($urandom_range(0, 511))});
      end else if (kind == 1) begin
        write_reg(bpc_pkg::CFG_COEF_A, 48'({$urandom, $urandom}));
        write_reg(bpc_pkg::CFG_COEF_B, 48'({$urandom, $urandom}));
        write_reg(bpc_pkg::CFG_COEF_C, 48'({$urandom, $urandom}));
        write_reg(bpc_pkg::CFG_COEF_D, {16'($urandom), $urandom});
      end else if (kind == 2) begin
        write_reg(bpc_pkg::CFG_COEF_A, 48'h7FFF_7FFF_7FFF);
        write_reg(bpc_pkg::CFG_COEF_B, 48'hFFFF_FFFF_0000);
        write_reg(bpc_pkg::CFG_COEF_C, 48'h0000_7FFF_7FFF);
        write_reg(bpc_pkg::CFG_COEF_D, 48'h0000_7FFF_8000);
      end else begin
        write_reg(bpc_pkg::CFG_COEF_A, 48'h8000_8000_8000);
        write_reg(bpc_pkg::CFG_COEF_B, 48'h8000_0001_FFFF);
        write_reg(bpc_pkg::CFG_COEF_C, 48'h0000_8000_8000);
        write_reg(bpc_pkg::CFG_COEF_D, 48'h0000_8000_0001);
      end
      write_reg(bpc_pkg::CFG_OSS, 48'(ph % 4));
      @(posedge clk);
      ac6_now = cal_b[15:0];

      for (int n = 0; n < 130; n++) begin
        if (ph == 2 && n == 10) hold_req = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            ut = 16'($urandom_range(20000, 36000));
            up = 19'($urandom_range(15000, 45000) << cal_oss);
          end
          6: begin
            ut = ac6_now;
            up = 19'($urandom);
          end
          default: begin
            ut = 16'($urandom);
            up = 19'($urandom);
          end
        endcase
        // no sender gaps while the receiver holds off, so the pipe fills up
        send_sample(ut, up, 1'b0, none, !(ph == 2 && n < 120));
      end
    end

    s_tvalid <= 1'b0;
    wait_idle();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bpc_pkg.sv
design/bpc_udiv.sv
design/baro_pressure_temp_compensation_core.sv
bench/baro_pressure_temp_compensation_core_test.sv
